/* hw/rtl/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared constants, operation codes and the command and status bundles that
// join the controller of the RPN calculator to its datapath.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int DATA_W          = 32;
   localparam int ACC_W           = 2 * DATA_W;
   localparam int OP_W            = 3;
   localparam int DEPTH_OUT_W     = 5;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request word
      logic push;       // push the operand and answer
      logic clear;      // empty the stack
      logic pop_b;      // pop the top entry (read issue)
      logic pop_a;      // pop the next entry (read issue)
      logic cap_b;      // capture b from the stack read
      logic cap_a;      // capture a from the stack read
      logic calc;       // add, subtract or multiply into the accumulator
      logic round;      // drop the fraction bits of a product
      logic clip;       // clamp the accumulator into the result
      logic div_start;  // launch the iterative divider
      logic div_take;   // form the result from the quotient
      logic finish;     // push the result and answer
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            div_done;
   } dp_stat_type;

endpackage

/* hw/rtl/rpn_ram.sv */
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rpn_div.sv */
// ----------------------------------------------------------------------------
// rpn_div
// Iterative restoring divider, one quotient bit per cycle. It divides a
// 64-bit magnitude by a 32-bit magnitude and flags quotients that need more
// than 32 bits before any iteration is spent.
// ----------------------------------------------------------------------------
module rpn_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rpn_pkg::DATA_W-1:0]  num_hi,
   input  logic [rpn_pkg::DATA_W-1:0]  num_lo,
   input  logic [rpn_pkg::DATA_W-1:0]  den,
   output logic                        done,
   output logic                        ovf,
   output logic [rpn_pkg::DATA_W-1:0]  quot
);

   localparam int DW    = rpn_pkg::DATA_W;
   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    dq_ff, dq_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             fits;

   always_comb begin
      trial   = {rem_ff, dq_ff[DW-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = den;
         if (num_hi >= den) begin
            // The quotient cannot fit in 32 bits; a zero divisor lands here too.
            ovf_in  = 1'b1;
            done_in = 1'b1;
            run_in  = 1'b0;
         end else begin
            ovf_in = 1'b0;
            rem_in = num_hi;
            dq_in  = num_lo;
            cnt_in = CNT_W'(DW);
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         dq_in  = {dq_ff[DW-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quot = dq_ff;

endmodule

/* hw/rtl/rpn_dp.sv */
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath of the RPN calculator: stack memory and depth counter, operand
// registers, accumulator with adder and multiplier, the divider and the
// result registers.
// ----------------------------------------------------------------------------
module rpn_dp #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [rpn_pkg::OP_W-1:0]            req_op,
   input  logic signed [rpn_pkg::DATA_W-1:0]   req_operand,
   input  rpn_pkg::dp_cmd_type                 cmd,
   output rpn_pkg::dp_stat_type                stat,
   output logic                                rsp_strobe,
   output logic signed [rpn_pkg::DATA_W-1:0]   rsp_value,
   output logic                                rsp_saturated,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_stack_overflow,
   output logic [rpn_pkg::DEPTH_OUT_W-1:0]     rsp_stack_depth
);

   localparam int DW = rpn_pkg::DATA_W;
   localparam int AW = rpn_pkg::ACC_W;
   localparam int MW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic signed [AW-1:0] RND = (64'sd1 <<< FRAC_BITS) - 64'sd1;

   logic [rpn_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [DW-1:0]              operand_ff, operand_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic signed [DW-1:0]              a_ff, a_in, b_ff, b_in;
   logic                              a_ok_ff, a_ok_in, b_ok_ff, b_ok_in;
   logic signed [AW-1:0]              acc_ff, acc_in;
   logic signed [DW-1:0]              res_ff, res_in;
   logic                              sat_ff, sat_in, dz_ff, dz_in;
   logic                              strobe_ff, strobe_in;
   logic signed [DW-1:0]              value_ff, value_in;
   logic                              rsat_ff, rsat_in, rdz_ff, rdz_in, rovf_ff, rovf_in;
   logic [rpn_pkg::DEPTH_OUT_W-1:0]   depth_ff, depth_in;

   logic                              full;
   logic                              empty;
   logic [CW-1:0]                     count_m1;
   logic                              wr_en;
   logic [DW-1:0]                     wr_data;
   logic [DW-1:0]                     rd_data;
   logic signed [AW-1:0]              prod;
   logic [DW-1:0]                     a_mag, b_mag;
   logic [AW-1:0]                     num_mag;
   logic                              div_done, div_ovf;
   logic [DW-1:0]                     div_quot;
   logic                              neg;

   assign full     = (count_ff == CW'(STACK_DEPTH));
   assign empty    = (count_ff == '0);
   assign count_m1 = count_ff - CW'(1);
   assign wr_en    = (cmd.push && !full) || cmd.finish;
   assign wr_data  = cmd.push ? operand_ff : res_ff;

   rpn_ram #(
      .WIDTH (DW),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[MW-1:0]),
      .wr_data (wr_data),
      .rd_addr (count_m1[MW-1:0]),
      .rd_data (rd_data)
   );

   assign a_mag   = a_ff[DW-1] ? DW'(-a_ff) : a_ff;
   assign b_mag   = b_ff[DW-1] ? DW'(-b_ff) : b_ff;
   assign num_mag = AW'(a_mag) << FRAC_BITS;
   assign neg     = a_ff[DW-1] ^ b_ff[DW-1];
   assign prod    = a_ff * b_ff;

   rpn_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .num_hi (num_mag[AW-1:DW]),
      .num_lo (num_mag[DW-1:0]),
      .den    (b_mag),
      .done   (div_done),
      .ovf    (div_ovf),
      .quot   (div_quot)
   );

   always_comb begin
      op_in      = op_ff;
      operand_in = operand_ff;
      count_in   = count_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      a_ok_in    = a_ok_ff;
      b_ok_in    = b_ok_ff;
      acc_in     = acc_ff;
      res_in     = res_ff;
      sat_in     = sat_ff;
      dz_in      = dz_ff;
      strobe_in  = cmd.push || cmd.finish;
      value_in   = value_ff;
      rsat_in    = rsat_ff;
      rdz_in     = rdz_ff;
      rovf_in    = rovf_ff;
      depth_in   = depth_ff;

      if (cmd.load) begin
         op_in      = req_op;
         operand_in = req_operand;
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.push && !full) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pop_b) begin
         b_ok_in = !empty;
         if (!empty) begin
            count_in = count_m1;
         end
      end
      if (cmd.pop_a) begin
         a_ok_in = !empty;
         if (!empty) begin
            count_in = count_m1;
         end
      end
      if (cmd.cap_b) begin
         b_in = b_ok_ff ? rd_data : '0;
      end
      if (cmd.cap_a) begin
         a_in = a_ok_ff ? rd_data : '0;
      end
      if (cmd.calc) begin
         case (op_ff)
            rpn_pkg::OP_ADD: acc_in = AW'(a_ff) + AW'(b_ff);
            rpn_pkg::OP_SUB: acc_in = AW'(a_ff) - AW'(b_ff);
            rpn_pkg::OP_MUL: acc_in = prod;
            default:         acc_in = acc_ff;
         endcase
      end
      if (cmd.round) begin
         // Truncate toward zero: bias negative products before the shift.
         acc_in = (acc_ff + (acc_ff[AW-1] ? RND : 64'sd0)) >>> FRAC_BITS;
      end
      if (cmd.clip) begin
         dz_in = 1'b0;
         if (acc_ff[AW-1:DW-1] != {(AW-DW+1){acc_ff[AW-1]}}) begin
            sat_in = 1'b1;
            res_in = acc_ff[AW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
         end else begin
            sat_in = 1'b0;
            res_in = acc_ff[DW-1:0];
         end
      end
      if (cmd.div_take) begin
         sat_in = 1'b0;
         dz_in  = 1'b0;
         if (b_ff == '0) begin
            dz_in  = 1'b1;
            res_in = a_ff[DW-1] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
         end else if (div_ovf) begin
            sat_in = 1'b1;
            res_in = neg ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
         end else if (!neg) begin
            if (div_quot[DW-1]) begin
               sat_in = 1'b1;
               res_in = rpn_pkg::Q_MAX;
            end else begin
               res_in = div_quot;
            end
         end else if (div_quot[DW-1] && (div_quot[DW-2:0] != '0)) begin
            sat_in = 1'b1;
            res_in = rpn_pkg::Q_MIN;
         end else begin
            res_in = DW'(-div_quot);
         end
      end
      if (cmd.finish) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.push) begin
         value_in = operand_ff;
         rsat_in  = 1'b0;
         rdz_in   = 1'b0;
         rovf_in  = full;
         depth_in = rpn_pkg::DEPTH_OUT_W'(count_in);
      end
      if (cmd.finish) begin
         value_in = res_ff;
         rsat_in  = sat_ff;
         rdz_in   = dz_ff;
         rovf_in  = 1'b0;
         depth_in = rpn_pkg::DEPTH_OUT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      op_ff      <= op_in;
      operand_ff <= operand_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      a_ok_ff    <= a_ok_in;
      b_ok_ff    <= b_ok_in;
      acc_ff     <= acc_in;
      res_ff     <= res_in;
      sat_ff     <= sat_in;
      dz_ff      <= dz_in;
      value_ff   <= value_in;
      rsat_ff    <= rsat_in;
      rdz_ff     <= rdz_in;
      rovf_ff    <= rovf_in;
      depth_ff   <= depth_in;
   end

   assign stat.op       = op_ff;
   assign stat.div_done = div_done;

   assign rsp_strobe         = strobe_ff;
   assign rsp_value          = value_ff;
   assign rsp_saturated      = rsat_ff;
   assign rsp_divide_by_zero = rdz_ff;
   assign rsp_stack_overflow = rovf_ff;
   assign rsp_stack_depth    = depth_ff;

endmodule

/* hw/rtl/rpn_ctrl.sv */
// ----------------------------------------------------------------------------
// rpn_ctrl
// Controller of the RPN calculator: sequences pops, arithmetic, the divider
// and the final push for each accepted word.
// ----------------------------------------------------------------------------
module rpn_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rpn_pkg::dp_stat_type  stat,
   output rpn_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_A,
      S_GET_A,
      S_CALC,
      S_ROUND,
      S_CLIP,
      S_DIV_GO,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op)
               rpn_pkg::OP_PUSH: begin
                  cmd.push = 1'b1;
                  state_in = S_IDLE;
               end
               rpn_pkg::OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
               rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                  cmd.pop_b = 1'b1;
                  state_in  = S_POP_A;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_POP_A: begin
            cmd.pop_a = 1'b1;
            cmd.cap_b = 1'b1;
            state_in  = S_GET_A;
         end
         S_GET_A: begin
            cmd.cap_a = 1'b1;
            state_in  = (stat.op == rpn_pkg::OP_DIV) ? S_DIV_GO : S_CALC;
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = (stat.op == rpn_pkg::OP_MUL) ? S_ROUND : S_CLIP;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            state_in  = S_CLIP;
         end
         S_CLIP: begin
            cmd.clip = 1'b1;
            state_in = S_FINISH;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

/* hw/rtl/rpn_stack_calculator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse Polish calculator over a bounded stack of signed Q16.16 words.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                                         Handshake
//   request    req_op, req_operand                           start && !busy
//   response   rsp_value, rsp_saturated, rsp_divide_by_zero, rsp_strobe, 1 cycle
//              rsp_stack_overflow, rsp_stack_depth
//
// A push or clear word keeps busy high for the decode state alone; add and
// subtract also pass pop, capture, calc, clip and finish, multiply also round,
// and divide runs the divider in place of calc and clip, one quotient bit
// per cycle, ending early on a zero divisor or an oversized quotient. The
// response strobe rises at the same edge at which busy falls.
// Reset is synchronous and clears the stack depth, the controller and the
// strobe; stack memory contents are never cleared, since only entries below
// the depth are read. The receiver cannot stall: each answer is shown for
// exactly one cycle, and clear words and unused op codes give no answer.
//
// Arithmetic: add, subtract and multiply saturate to the 32-bit range and set
// rsp_saturated. The product keeps the full 64 bits and drops FRAC_BITS
// fraction bits with truncation toward zero. Division computes
// (a << FRAC_BITS) / b on magnitudes, truncated toward zero; a zero divisor
// returns the extreme value of a's sign with rsp_divide_by_zero set.
// Popping an empty stack reads as zero, and a push onto a full stack is
// dropped with rsp_stack_overflow set while the operand is still echoed.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = rpn_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [rpn_pkg::OP_W-1:0]            req_op,
   input  logic signed [rpn_pkg::DATA_W-1:0]   req_operand,
   output logic                                rsp_strobe,
   output logic signed [rpn_pkg::DATA_W-1:0]   rsp_value,
   output logic                                rsp_saturated,
   output logic                                rsp_divide_by_zero,
   output logic                                rsp_stack_overflow,
   output logic [rpn_pkg::DEPTH_OUT_W-1:0]     rsp_stack_depth
);

   // Command and status bundles between the controller and the datapath.
   rpn_pkg::dp_cmd_type  cmd;
   rpn_pkg::dp_stat_type stat;

   // The controller only accepts a word while idle, so start is gated by the
   // state machine itself.
   rpn_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // The datapath holds the stack, the arithmetic and the answer registers.
   rpn_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_operand        (req_operand),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_value          (rsp_value),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_stack_overflow (rsp_stack_overflow),
      .rsp_stack_depth    (rsp_stack_depth)
   );

`ifndef ASSERT_OFF
   // An accepted word always occupies the controller, raising busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // Every word passes through at least one busy state, so answers never abut.
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two answers in consecutive cycles");

   // A zero divisor is reported alone, never as saturation or overflow.
   a_dz_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_divide_by_zero) |-> (!rsp_saturated && !rsp_stack_overflow))
      else $error("divide by zero answer carries other flags");

   // A dropped push leaves the stack full.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_stack_overflow) |->
         (rsp_stack_depth == rpn_pkg::DEPTH_OUT_W'(STACK_DEPTH)))
      else $error("overflow reported while stack not full");
`endif

endmodule
